// File: src/etpg_pkg.sv
// shared types and constants of the encoder tuned pulse generator
`default_nettype none

package etpg_pkg;

    localparam int VAL_W      = 16;
    localparam int STEP_W     = 10;
    localparam int KONST_W    = 24;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 3;

    localparam int SPEED_PRESCALE = 256;
    localparam int RPM_PRESCALE   = 1024;
    localparam int SPEED_PRE_W    = (SPEED_PRESCALE > 1) ? $clog2(SPEED_PRESCALE) : 1;
    localparam int RPM_PRE_W      = (RPM_PRESCALE > 1) ? $clog2(RPM_PRESCALE) : 1;
    localparam logic [SPEED_PRE_W-1:0] SPEED_PRE_LAST = SPEED_PRE_W'(SPEED_PRESCALE - 1);
    localparam logic [RPM_PRE_W-1:0]   RPM_PRE_LAST   = RPM_PRE_W'(RPM_PRESCALE - 1);

    localparam int DIV_CNT_W = $clog2(KONST_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(KONST_W - 1);

    // result word layout
    localparam int OUT_SPEED_POS  = 2;
    localparam int OUT_RPM_POS    = OUT_SPEED_POS + VAL_W;
    localparam int OUT_ON_POS     = OUT_RPM_POS + VAL_W;
    localparam int OUT_FIELDS_W   = OUT_ON_POS + 2;
    localparam int OUT_W          = ((OUT_FIELDS_W + 7) / 8) * 8;

    // reset values
    localparam logic [VAL_W-1:0]   SPEED_VALUE_RST = 16'd20;
    localparam logic [VAL_W-1:0]   RPM_VALUE_RST   = 16'd800;
    localparam logic [VAL_W-1:0]   SPEED_TOP_RST   = 16'd2196;
    localparam logic [VAL_W-1:0]   RPM_TOP_RST     = 16'd194;
    localparam logic [VAL_W-1:0]   SPEED_MIN_RST   = 16'd1;
    localparam logic [VAL_W-1:0]   SPEED_MAX_RST   = 16'd180;
    localparam logic [STEP_W-1:0]  SPEED_STEP_RST  = 10'd1;
    localparam logic [VAL_W-1:0]   RPM_MIN_RST     = 16'd800;
    localparam logic [VAL_W-1:0]   RPM_MAX_RST     = 16'd8000;
    localparam logic [STEP_W-1:0]  RPM_STEP_RST    = 10'd100;
    localparam logic [KONST_W-1:0] SPEED_KONST_RST = 24'd43945;
    localparam logic [KONST_W-1:0] RPM_KONST_RST   = 24'd156250;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_ENC    = 2'd1,
        OP_BUTTON = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_MIN   = 3'd0,
        REG_SPEED_MAX   = 3'd1,
        REG_SPEED_STEP  = 3'd2,
        REG_RPM_MIN     = 3'd3,
        REG_RPM_MAX     = 3'd4,
        REG_RPM_STEP    = 3'd5,
        REG_SPEED_KONST = 3'd6,
        REG_RPM_KONST   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic finish;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic needs_div;
    } dp_status_t;

endpackage

`default_nettype wire

// File: src/etpg_ctrl.sv
// controller state machine: handshakes, divide sequencing, result valid
`default_nettype none

module etpg_ctrl
    import etpg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = !valid_reg || m_tready;
                if (s_tvalid && s_tready)
                begin
                    cmd.accept = 1'b1;
                    if (status.needs_div)
                    begin
                        state_next = ST_DIV;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cmd.out_load = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                cmd.finish   = 1'b1;
                cmd.out_load = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    assign m_tvalid = valid_reg;

endmodule

`default_nettype wire

// File: src/etpg_dp.sv
// datapath: channel state, limits, restoring divider and result register
`default_nettype none

module etpg_dp
    import etpg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic [OP_W-1:0]       op,
    input  wire logic                  channel,
    input  wire logic                  enc_a,
    input  wire logic                  enc_b,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic [OUT_W-1:0]           out_data
);

    logic [VAL_W-1:0]       value_reg [2];
    logic [VAL_W-1:0]       value_next [2];
    logic [VAL_W-1:0]       top_reg [2];
    logic [VAL_W-1:0]       top_next [2];
    logic [VAL_W-1:0]       count_reg [2];
    logic [VAL_W-1:0]       count_next [2];
    logic                   level_reg [2];
    logic                   level_next [2];
    logic                   enabled_reg [2];
    logic                   enabled_next [2];
    logic [VAL_W-1:0]       vmin_reg [2];
    logic [VAL_W-1:0]       vmin_next [2];
    logic [VAL_W-1:0]       vmax_reg [2];
    logic [VAL_W-1:0]       vmax_next [2];
    logic [STEP_W-1:0]      step_reg [2];
    logic [STEP_W-1:0]      step_next [2];
    logic [KONST_W-1:0]     konst_reg [2];
    logic [KONST_W-1:0]     konst_next [2];
    logic [SPEED_PRE_W-1:0] speed_pre_reg, speed_pre_next;
    logic [RPM_PRE_W-1:0]   rpm_pre_reg, rpm_pre_next;
    logic                   sel_reg, sel_next;
    logic [KONST_W-1:0]     quo_reg, quo_next;
    logic [VAL_W-1:0]       rem_reg, rem_next;
    logic [VAL_W-1:0]       divisor_reg, divisor_next;
    logic [OUT_W-1:0]       out_reg, out_next;

    logic [VAL_W-1:0]       cur_v;
    logic [VAL_W-1:0]       cur_step;
    logic [VAL_W:0]         up_sum;
    logic [VAL_W-1:0]       up_v;
    logic [VAL_W-1:0]       dn_v;
    logic [VAL_W-1:0]       new_v;
    logic                   go_up;
    logic                   can_move;
    logic                   wrap [2];
    logic [VAL_W:0]         rem_shift;
    logic                   rem_ge;
    logic [KONST_W-1:0]     quo_m1;
    logic [VAL_W-1:0]       top_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg[0]   <= SPEED_VALUE_RST;
            value_reg[1]   <= RPM_VALUE_RST;
            top_reg[0]     <= SPEED_TOP_RST;
            top_reg[1]     <= RPM_TOP_RST;
            count_reg[0]   <= '0;
            count_reg[1]   <= '0;
            level_reg[0]   <= 1'b0;
            level_reg[1]   <= 1'b0;
            enabled_reg[0] <= 1'b1;
            enabled_reg[1] <= 1'b1;
            vmin_reg[0]    <= SPEED_MIN_RST;
            vmin_reg[1]    <= RPM_MIN_RST;
            vmax_reg[0]    <= SPEED_MAX_RST;
            vmax_reg[1]    <= RPM_MAX_RST;
            step_reg[0]    <= SPEED_STEP_RST;
            step_reg[1]    <= RPM_STEP_RST;
            konst_reg[0]   <= SPEED_KONST_RST;
            konst_reg[1]   <= RPM_KONST_RST;
            speed_pre_reg  <= '0;
            rpm_pre_reg    <= '0;
            sel_reg        <= 1'b0;
        end
        else
        begin
            value_reg     <= value_next;
            top_reg       <= top_next;
            count_reg     <= count_next;
            level_reg     <= level_next;
            enabled_reg   <= enabled_next;
            vmin_reg      <= vmin_next;
            vmax_reg      <= vmax_next;
            step_reg      <= step_next;
            konst_reg     <= konst_next;
            speed_pre_reg <= speed_pre_next;
            rpm_pre_reg   <= rpm_pre_next;
            sel_reg       <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        out_reg     <= out_next;
    end

    // encoder step of the selected channel
    always_comb
    begin
        cur_v    = value_reg[channel];
        cur_step = VAL_W'(step_reg[channel]);
        go_up    = (enc_a == enc_b);
        up_sum   = {1'b0, cur_v} + {1'b0, cur_step};
        up_v     = up_sum[VAL_W] ? {VAL_W{1'b1}} : up_sum[VAL_W-1:0];
        dn_v     = (cur_step >= cur_v) ? VAL_W'(1) : cur_v - cur_step;
        new_v    = go_up ? up_v : dn_v;
        can_move = enabled_reg[channel]
                   && (go_up ? (cur_v < vmax_reg[channel]) : (cur_v > vmin_reg[channel]));
        status.needs_div = (op_t'(op) == OP_ENC) && can_move;
    end

    // divider step and top from quotient
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[KONST_W-1]};
        rem_ge    = rem_shift >= {1'b0, divisor_reg};
        quo_m1    = quo_reg - KONST_W'(1);
        if (quo_reg == '0)
        begin
            top_calc = '0;
        end
        else if (|quo_m1[KONST_W-1:VAL_W])
        begin
            top_calc = {VAL_W{1'b1}};
        end
        else
        begin
            top_calc = quo_m1[VAL_W-1:0];
        end
    end

    assign wrap[0] = (speed_pre_reg == SPEED_PRE_LAST);
    assign wrap[1] = (rpm_pre_reg == RPM_PRE_LAST);

    always_comb
    begin
        value_next     = value_reg;
        top_next       = top_reg;
        count_next     = count_reg;
        level_next     = level_reg;
        enabled_next   = enabled_reg;
        vmin_next      = vmin_reg;
        vmax_next      = vmax_reg;
        step_next      = step_reg;
        konst_next     = konst_reg;
        speed_pre_next = speed_pre_reg;
        rpm_pre_next   = rpm_pre_reg;
        sel_next       = sel_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;

        if (cmd.accept)
        begin
            case (op_t'(op))
                OP_TICK:
                begin
                    if (enabled_reg[0])
                    begin
                        speed_pre_next = wrap[0] ? '0 : speed_pre_reg + 1'b1;
                    end
                    if (enabled_reg[1])
                    begin
                        rpm_pre_next = wrap[1] ? '0 : rpm_pre_reg + 1'b1;
                    end
                    for (int i = 0; i < 2; i++)
                    begin
                        if (enabled_reg[i] && wrap[i])
                        begin
                            if (count_reg[i] >= top_reg[i])
                            begin
                                count_next[i] = '0;
                                level_next[i] = !level_reg[i];
                            end
                            else
                            begin
                                count_next[i] = count_reg[i] + 1'b1;
                            end
                        end
                    end
                end
                OP_ENC:
                begin
                    if (can_move)
                    begin
                        value_next[channel] = new_v;
                        sel_next            = channel;
                        quo_next            = konst_reg[channel];
                        rem_next            = '0;
                        divisor_next        = (new_v == '0) ? VAL_W'(1) : new_v;
                    end
                end
                OP_BUTTON:
                begin
                    enabled_next[channel] = !enabled_reg[channel];
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.div_step)
        begin
            quo_next = {quo_reg[KONST_W-2:0], rem_ge};
            rem_next = rem_ge ? VAL_W'(rem_shift - {1'b0, divisor_reg}) : rem_shift[VAL_W-1:0];
        end

        if (cmd.finish)
        begin
            top_next[sel_reg] = top_calc;
            if (count_reg[sel_reg] > top_calc)
            begin
                count_next[sel_reg] = '0;
            end
        end

        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SPEED_MIN:   vmin_next[0]  = cfg_data[VAL_W-1:0];
                REG_SPEED_MAX:   vmax_next[0]  = cfg_data[VAL_W-1:0];
                REG_SPEED_STEP:  step_next[0]  = cfg_data[STEP_W-1:0];
                REG_RPM_MIN:     vmin_next[1]  = cfg_data[VAL_W-1:0];
                REG_RPM_MAX:     vmax_next[1]  = cfg_data[VAL_W-1:0];
                REG_RPM_STEP:    step_next[1]  = cfg_data[STEP_W-1:0];
                REG_SPEED_KONST: konst_next[0] = cfg_data[KONST_W-1:0];
                REG_RPM_KONST:   konst_next[1] = cfg_data[KONST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // result word from the state after the item
    always_comb
    begin
        out_next = out_reg;
        if (cmd.out_load)
        begin
            out_next = {
                (OUT_W - OUT_FIELDS_W)'(0),
                enabled_next[1],
                enabled_next[0],
                value_next[1],
                value_next[0],
                level_next[1] & enabled_next[1],
                level_next[0] & enabled_next[0]
            };
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// File: src/encoder_tuned_pulse_generator.sv
// top level of the encoder tuned pulse generator
//
// two-channel square-wave source for speed and tacho pulses. input words on
// s_tvalid/s_tready carry an op in s_tuser (tick, encoder edge, button) and
// the encoder phase levels in s_tdata. every accepted word gives exactly one
// result word on m_tvalid/m_tready with both pulse levels, both settings and
// both enable flags as they stand after the word.
// ticks, buttons and encoder edges that change nothing: the result is
// registered at accept and offered in the next cycle; the next word is taken
// in the same cycle as the result leaves, so one word per cycle is sustained
// while m_tready is high. an encoder edge that moves a setting runs the
// 24-bit restoring divider for the new period top, one quotient bit per
// cycle, then loads the result; no word is taken meanwhile.
// a stalled result holds in the output register; input is refused until it is
// taken or leaves in the cycle the next word enters.
// reset restores the default settings, limits and constants, both channels
// enabled with low pins. config words on cfg_valid are always taken.
`default_nettype none

module encoder_tuned_pulse_generator
    import etpg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // enc_a, enc_b
    input  wire logic [IN_USER_W-1:0]  s_tuser,   // op[1:0], channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // speed_pulse, tacho_pulse, speed_now, rpm_now, speed_on, tacho_on
    output logic [OUT_W-1:0]           m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    etpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    etpg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (s_tuser[OP_W-1:0]),
        .channel   (s_tuser[OP_W]),
        .enc_a     (s_tdata[0]),
        .enc_b     (s_tdata[1]),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata)
    );

    a_accept_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
        else $error("word accepted while result register full");

    a_div_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.needs_div) |=> (!m_tvalid && !s_tready))
        else $error("result or accept during divide");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (!s_tready && !cmd.out_load))
        else $error("divider step overlaps accept or load");

    a_value_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[OUT_RPM_POS-1:OUT_SPEED_POS] != '0)
                      && (m_tdata[OUT_ON_POS-1:OUT_RPM_POS] != '0)))
        else $error("setting reached zero");

endmodule

`default_nettype wire
